// ===== hw/rtl/mfbfs_pkg.sv =====
// Shared types and constants of the max-flow block.
// No dependencies; the controller and datapath both use it.
package mfbfs_pkg;

    localparam int FLOW_BITS = 20;
    localparam int NODE_BITS = 4;
    localparam int IN_CAP_BITS = 16;
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_RUN = 1'b1;
    localparam logic STAT_OK = 1'b0;
    localparam logic STAT_SAME = 1'b1;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_CLR,
        OP_LOAD,
        OP_RUN,
        OP_COPY,
        OP_BFS_INIT,
        OP_POP,
        OP_SCAN,
        OP_WALK_INIT,
        OP_WALK_RD,
        OP_WALK_EV,
        OP_UPD_INIT,
        OP_UPD_RDF,
        OP_UPD_WRF,
        OP_UPD_WRR,
        OP_ADD
    } dp_op_t;

    typedef struct packed {
        logic clr_done;
        logic copy_done;
        logic queue_empty;
        logic scan_done;
        logic reached;
        logic at_src;
        logic run_same;
        logic run_bad;
    } dp_stat_t;

endpackage

// ===== hw/rtl/mfbfs_dp.sv =====
// Datapath of the max-flow block: capacity and residual memories, BFS state,
// path walk and flow accumulator. Depends on mfbfs_pkg; driven by mfbfs_ctrl.
module mfbfs_dp #(
    parameter int NODES = 16,
    parameter int CAP_BITS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  mfbfs_pkg::dp_op_t               op,
    input  logic [mfbfs_pkg::NODE_BITS-1:0] from_node,
    input  logic [mfbfs_pkg::NODE_BITS-1:0] to_node,
    input  logic [mfbfs_pkg::IN_CAP_BITS-1:0] capacity,
    input  logic [mfbfs_pkg::NODE_BITS-1:0] source_node,
    input  logic [mfbfs_pkg::NODE_BITS-1:0] sink_node,
    output logic [mfbfs_pkg::FLOW_BITS-1:0] flow,
    output mfbfs_pkg::dp_stat_t             stat
);

    localparam int NW = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int AW = 2 * NW;
    localparam int DEPTH = 2 ** AW;
    localparam int RW = CAP_BITS + 1;
    localparam int SW = (RW + 1 > mfbfs_pkg::FLOW_BITS + 1) ? RW + 1
                                                            : mfbfs_pkg::FLOW_BITS + 1;

    logic [CAP_BITS-1:0] cap_mem [DEPTH];
    logic [RW-1:0]       res_mem [DEPTH];

    logic [AW:0]     cnt_reg;
    logic [CAP_BITS-1:0] cap_rd_reg;
    logic [RW-1:0]   res_rd_reg;
    logic [NW-1:0]   src_reg, dst_reg, u_reg, walk_v_reg, pend_v_reg;
    logic [NODES-1:0] visited_reg;
    logic [NW-1:0]   parent_reg [NODES];
    logic [NW-1:0]   queue_reg [NODES];
    logic [NW:0]     head_reg, tail_reg, v_cnt_reg;
    logic            pend_valid_reg;
    logic [RW-1:0]   bneck_reg;
    logic [mfbfs_pkg::FLOW_BITS-1:0] flow_reg;

    logic            from_ok, to_ok, src_ok, dst_ok;
    logic [NW-1:0]   walk_p;
    logic            res_we;
    logic [AW-1:0]   res_wa, res_ra;
    logic [RW-1:0]   res_wd;
    logic            enq;
    logic [SW-1:0]   flow_sum;

    assign from_ok = {3'b000, from_node} < 7'(NODES);
    assign to_ok = {3'b000, to_node} < 7'(NODES);
    assign src_ok = {3'b000, source_node} < 7'(NODES);
    assign dst_ok = {3'b000, sink_node} < 7'(NODES);
    assign walk_p = parent_reg[walk_v_reg];
    assign enq = (op == mfbfs_pkg::OP_SCAN) && pend_valid_reg
                 && !visited_reg[pend_v_reg] && (res_rd_reg != '0);
    assign flow_sum = SW'(flow_reg) + SW'(bneck_reg);

    // residual port select
    always_comb
    begin
        res_we = 1'b0;
        res_wa = '0;
        res_wd = '0;
        res_ra = '0;
        case (op)
            mfbfs_pkg::OP_COPY:
            begin
                res_we = (cnt_reg != '0);
                res_wa = AW'(cnt_reg - 1'b1);
                res_wd = RW'(cap_rd_reg);
            end
            mfbfs_pkg::OP_SCAN:
                res_ra = {u_reg, v_cnt_reg[NW-1:0]};
            mfbfs_pkg::OP_WALK_RD,
            mfbfs_pkg::OP_UPD_RDF:
                res_ra = {walk_p, walk_v_reg};
            mfbfs_pkg::OP_UPD_WRF:
            begin
                res_we = 1'b1;
                res_wa = {walk_p, walk_v_reg};
                res_wd = res_rd_reg - bneck_reg;
                res_ra = {walk_v_reg, walk_p};
            end
            mfbfs_pkg::OP_UPD_WRR:
            begin
                res_we = 1'b1;
                res_wa = {walk_v_reg, walk_p};
                res_wd = res_rd_reg + bneck_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (op == mfbfs_pkg::OP_CLR)
            cap_mem[cnt_reg[AW-1:0]] <= '0;
        else if (op == mfbfs_pkg::OP_LOAD && from_ok && to_ok)
            cap_mem[{NW'(from_node), NW'(to_node)}] <= CAP_BITS'(capacity);
        if (op == mfbfs_pkg::OP_COPY && !cnt_reg[AW])
            cap_rd_reg <= cap_mem[cnt_reg[AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (res_we)
            res_mem[res_wa] <= res_wd;
        res_rd_reg <= res_mem[res_ra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            visited_reg <= '0;
            head_reg <= '0;
            tail_reg <= '0;
            v_cnt_reg <= '0;
            pend_valid_reg <= 1'b0;
            flow_reg <= '0;
        end
        else
        begin
            case (op)
                mfbfs_pkg::OP_CLR,
                mfbfs_pkg::OP_COPY:
                    cnt_reg <= cnt_reg + 1'b1;
                mfbfs_pkg::OP_RUN:
                begin
                    cnt_reg <= '0;
                    flow_reg <= '0;
                end
                mfbfs_pkg::OP_BFS_INIT:
                begin
                    visited_reg <= NODES'(1) << src_reg;
                    head_reg <= '0;
                    tail_reg <= (NW+1)'(1);
                end
                mfbfs_pkg::OP_POP:
                begin
                    head_reg <= head_reg + 1'b1;
                    v_cnt_reg <= '0;
                    pend_valid_reg <= 1'b0;
                end
                mfbfs_pkg::OP_SCAN:
                begin
                    pend_valid_reg <= (v_cnt_reg != (NW+1)'(NODES));
                    if (v_cnt_reg != (NW+1)'(NODES))
                        v_cnt_reg <= v_cnt_reg + 1'b1;
                    if (enq)
                    begin
                        visited_reg[pend_v_reg] <= 1'b1;
                        tail_reg <= tail_reg + 1'b1;
                    end
                end
                mfbfs_pkg::OP_ADD:
                    flow_reg <= flow_sum[SW-1:mfbfs_pkg::FLOW_BITS] != '0 ? '1
                              : flow_sum[mfbfs_pkg::FLOW_BITS-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // payload registers of the search and path walk
    always_ff @(posedge clk)
    begin
        case (op)
            mfbfs_pkg::OP_RUN:
            begin
                src_reg <= NW'(source_node);
                dst_reg <= NW'(sink_node);
            end
            mfbfs_pkg::OP_BFS_INIT:
            begin
                queue_reg[0] <= src_reg;
                parent_reg[src_reg] <= src_reg;
            end
            mfbfs_pkg::OP_POP:
                u_reg <= queue_reg[head_reg[NW-1:0]];
            mfbfs_pkg::OP_SCAN:
            begin
                pend_v_reg <= v_cnt_reg[NW-1:0];
                if (enq)
                begin
                    queue_reg[tail_reg[NW-1:0]] <= pend_v_reg;
                    parent_reg[pend_v_reg] <= u_reg;
                end
            end
            mfbfs_pkg::OP_WALK_INIT:
            begin
                walk_v_reg <= dst_reg;
                bneck_reg <= '1;
            end
            mfbfs_pkg::OP_WALK_EV:
            begin
                if (res_rd_reg < bneck_reg)
                    bneck_reg <= res_rd_reg;
                walk_v_reg <= walk_p;
            end
            mfbfs_pkg::OP_UPD_INIT:
                walk_v_reg <= dst_reg;
            mfbfs_pkg::OP_UPD_WRR:
                walk_v_reg <= walk_p;
            default:
            begin
            end
        endcase
    end

    assign flow = flow_reg;
    assign stat.clr_done = (cnt_reg[AW-1:0] == '1);
    assign stat.copy_done = cnt_reg[AW];
    assign stat.queue_empty = (head_reg == tail_reg);
    assign stat.scan_done = (v_cnt_reg == (NW+1)'(NODES)) && !pend_valid_reg;
    assign stat.reached = visited_reg[dst_reg];
    assign stat.at_src = (walk_v_reg == src_reg);
    assign stat.run_same = (source_node == sink_node);
    assign stat.run_bad = !src_ok || !dst_ok;

    a_visit_count: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(visited_reg) == 32'(tail_reg))
        else $error("visited count differs from queue tail");
    a_head_tail: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg <= tail_reg && tail_reg <= (NW+1)'(NODES))
        else $error("queue pointers out of order");

endmodule

// ===== hw/rtl/mfbfs_ctrl.sv =====
// Controller of the max-flow block: sequencing state machine, stream
// handshakes and result register. Depends on mfbfs_pkg; drives mfbfs_dp.
module mfbfs_ctrl (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            in_cmd,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [mfbfs_pkg::FLOW_BITS-1:0] out_flow,
    output logic                            out_status,
    output mfbfs_pkg::dp_op_t               op,
    input  mfbfs_pkg::dp_stat_t             stat,
    input  logic [mfbfs_pkg::FLOW_BITS-1:0] flow
);

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_COPY, S_BFS_INIT, S_POP, S_SCAN, S_CHECK,
        S_WALK_INIT, S_WALK_RD, S_WALK_EV, S_UPD_INIT, S_UPD_RDF,
        S_UPD_WRF, S_UPD_WRR, S_ADD, S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   err_reg, err_next;
    logic   out_valid_reg;
    logic [mfbfs_pkg::FLOW_BITS-1:0] out_flow_reg;
    logic   out_status_reg;
    logic   accept, emit;

    assign in_ready = (state_reg == S_IDLE);
    assign accept = in_valid && in_ready;
    assign emit = (state_reg == S_DONE) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next = state_reg;
        err_next = err_reg;
        op = mfbfs_pkg::OP_NONE;
        unique case (state_reg)
            S_CLEAR:
            begin
                op = mfbfs_pkg::OP_CLR;
                if (stat.clr_done)
                    state_next = S_IDLE;
            end
            S_IDLE:
                if (accept)
                begin
                    if (in_cmd == mfbfs_pkg::CMD_LOAD)
                        op = mfbfs_pkg::OP_LOAD;
                    else
                    begin
                        op = mfbfs_pkg::OP_RUN;
                        err_next = stat.run_same;
                        state_next = (stat.run_same || stat.run_bad) ? S_DONE : S_COPY;
                    end
                end
            S_COPY:
            begin
                op = mfbfs_pkg::OP_COPY;
                if (stat.copy_done)
                    state_next = S_BFS_INIT;
            end
            S_BFS_INIT:
            begin
                op = mfbfs_pkg::OP_BFS_INIT;
                state_next = S_POP;
            end
            S_POP:
                if (stat.queue_empty)
                    state_next = S_CHECK;
                else
                begin
                    op = mfbfs_pkg::OP_POP;
                    state_next = S_SCAN;
                end
            S_SCAN:
            begin
                op = mfbfs_pkg::OP_SCAN;
                if (stat.scan_done)
                    state_next = S_POP;
            end
            S_CHECK:
                state_next = stat.reached ? S_WALK_INIT : S_DONE;
            S_WALK_INIT:
            begin
                op = mfbfs_pkg::OP_WALK_INIT;
                state_next = S_WALK_RD;
            end
            S_WALK_RD:
                if (stat.at_src)
                    state_next = S_UPD_INIT;
                else
                begin
                    op = mfbfs_pkg::OP_WALK_RD;
                    state_next = S_WALK_EV;
                end
            S_WALK_EV:
            begin
                op = mfbfs_pkg::OP_WALK_EV;
                state_next = S_WALK_RD;
            end
            S_UPD_INIT:
            begin
                op = mfbfs_pkg::OP_UPD_INIT;
                state_next = S_UPD_RDF;
            end
            S_UPD_RDF:
                if (stat.at_src)
                    state_next = S_ADD;
                else
                begin
                    op = mfbfs_pkg::OP_UPD_RDF;
                    state_next = S_UPD_WRF;
                end
            S_UPD_WRF:
            begin
                op = mfbfs_pkg::OP_UPD_WRF;
                state_next = S_UPD_WRR;
            end
            S_UPD_WRR:
            begin
                op = mfbfs_pkg::OP_UPD_WRR;
                state_next = S_UPD_RDF;
            end
            S_ADD:
            begin
                op = mfbfs_pkg::OP_ADD;
                state_next = S_BFS_INIT;
            end
            S_DONE:
                if (emit)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            err_reg <= mfbfs_pkg::STAT_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            err_reg <= err_next;
            if (emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_flow_reg <= flow;
            out_status_reg <= err_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_flow = out_flow_reg;
    assign out_status = out_status_reg;

    a_same_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_status == mfbfs_pkg::STAT_SAME |-> out_flow == '0)
        else $error("error status with nonzero flow");
    a_same_done: assert property (@(posedge clk) disable iff (!rst_n)
        accept && in_cmd == mfbfs_pkg::CMD_RUN && stat.run_same |=> state_reg == S_DONE)
        else $error("equal source and sink did not finish at once");

endmodule

// ===== hw/rtl/max_flow_bfs_augmenting_top.sv =====
// Maximum flow by breadth-first augmenting paths over a dense capacity
// matrix. After reset the block clears its capacity memory, one entry per
// cycle over all 2**(2*ceil(log2 NODES)) entries (256 at 16 nodes), with
// s_tready low. A load transfer (tuser 0) writes one capacity and gives no
// result. A run transfer (tuser 1) copies the matrix into the residual
// memory, then per search scans each dequeued vertex's row at one residual
// read a cycle, and per found path walks the path edges for the bottleneck
// and then updates the forward and reverse residuals along the path. A run
// is bound by the residual memory, which has one read and one write port;
// one item is handled at a time. Equal source and sink give flow 0 with
// tuser status 1. Depends on mfbfs_pkg.
module max_flow_bfs_augmenting_top #(
    parameter int NODES = 16,
    parameter int CAP_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,  // from_node[3:0], to_node[7:4], capacity[23:8],
                                  // source_node[27:24], sink_node[31:28]
    input  logic        s_tuser,  // command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,  // max_flow[19:0], zero fill
    output logic        m_tuser   // status
);

    mfbfs_pkg::dp_op_t   op;
    mfbfs_pkg::dp_stat_t stat;
    logic [mfbfs_pkg::FLOW_BITS-1:0] flow, out_flow;

    mfbfs_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_cmd     (s_tuser),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_flow   (out_flow),
        .out_status (m_tuser),
        .op         (op),
        .stat       (stat),
        .flow       (flow)
    );

    mfbfs_dp #(
        .NODES    (NODES),
        .CAP_BITS (CAP_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .op          (op),
        .from_node   (s_tdata[3:0]),
        .to_node     (s_tdata[7:4]),
        .capacity    (s_tdata[23:8]),
        .source_node (s_tdata[27:24]),
        .sink_node   (s_tdata[31:28]),
        .flow        (flow),
        .stat        (stat)
    );

    assign m_tdata = {4'b0000, out_flow};

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for the max-flow block: loads capacities, runs flows,
// compares each total against an in-bench Edmonds-Karp predictor.
// Depends on mfbfs_pkg and max_flow_bfs_augmenting_top.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N = 16;

    typedef struct {
        logic [mfbfs_pkg::FLOW_BITS-1:0] flow;
        logic                            stat;
    } flow_result_t;

    class flow_board;
        logic [15:0]  cap_mem [N][N];
        flow_result_t pending [$];
        int           errors;
        int           runs;
        int           same_runs;
        int           loads;

        function void clear();
            for (int i = 0; i < N; i++)
                for (int j = 0; j < N; j++)
                    cap_mem[i][j] = '0;
            errors = 0;
            runs = 0;
            same_runs = 0;
            loads = 0;
        endfunction

        function automatic logic [mfbfs_pkg::FLOW_BITS-1:0] max_flow(int s, int t);
            longint res [N][N];
            bit     seen [N];
            int     par [N];
            int     q [N];
            int     hd;
            int     tl;
            int     u;
            int     v;
            longint neck;
            longint total;
            total = 0;
            for (int i = 0; i < N; i++)
                for (int j = 0; j < N; j++)
                    res[i][j] = cap_mem[i][j];
            forever
            begin
                for (int i = 0; i < N; i++)
                    seen[i] = 0;
                hd = 0;
                tl = 0;
                q[tl] = s;
                tl++;
                seen[s] = 1;
                par[s] = s;
                while (hd < tl)
                begin
                    u = q[hd];
                    hd++;
                    for (int w = 0; w < N; w++)
                        if (!seen[w] && res[u][w] > 0 && tl < N)
                        begin
                            q[tl] = w;
                            tl++;
                            par[w] = u;
                            seen[w] = 1;
                        end
                end
                if (!seen[t])
                    break;
                neck = 64'h7fff_ffff_ffff_ffff;
                v = t;
                for (int k = 0; v != s && k < N; k++)
                begin
                    if (res[par[v]][v] < neck)
                        neck = res[par[v]][v];
                    v = par[v];
                end
                v = t;
                for (int k = 0; v != s && k < N; k++)
                begin
                    res[par[v]][v] -= neck;
                    res[v][par[v]] += neck;
                    v = par[v];
                end
                total += neck;
                if (total > 20'hFFFFF)
                    total = 20'hFFFFF;
            end
            return total[mfbfs_pkg::FLOW_BITS-1:0];
        endfunction

        function void note_input(logic cmd, logic [31:0] d);
            flow_result_t r;
            int s;
            int t;
            if (cmd == mfbfs_pkg::CMD_LOAD)
            begin
                cap_mem[d[3:0]][d[7:4]] = d[23:8];
                loads++;
                return;
            end
            s = d[27:24];
            t = d[31:28];
            runs++;
            if (s == t)
            begin
                r.flow = '0;
                r.stat = mfbfs_pkg::STAT_SAME;
                same_runs++;
            end
            else
            begin
                r.flow = max_flow(s, t);
                r.stat = mfbfs_pkg::STAT_OK;
            end
            pending.push_back(r);
        endfunction

        function void check_result(logic [23:0] d, logic st);
            flow_result_t e;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result flow=%0d status=%0b", $time, d[19:0], st);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (d[19:0] !== e.flow || d[23:20] !== 4'b0)
            begin
                $display("%0t: max_flow expected %0d actual %0d (tdata %h)",
                         $time, e.flow, d[19:0], d);
                errors++;
            end
            if (st !== e.stat)
            begin
                $display("%0t: status expected %0b actual %0b", $time, e.stat, st);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic        m_tuser;

    flow_board board;
    int  src_idle_pct;
    int  dst_stall_pct;
    int  hold_off;
    longint cycles;

    max_flow_bfs_augmenting_top DUT (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    // Receiver: random stall, or a long hold-off when requested.
    initial
    begin
        m_tready = 0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                board.check_result(m_tdata, m_tuser);
            if (hold_off > 0)
            begin
                hold_off <= hold_off - 1;
                m_tready <= 0;
            end
            else
                m_tready <= ($urandom_range(99) >= dst_stall_pct);
        end
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > 64'd40_000_000)
            begin
                $display("tb_top: FAIL");
                $finish;
            end
        end
    end

    // Offer one transfer; idle gaps come before it.
    task automatic send(logic cmd, logic [31:0] d);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 0;
            @(posedge clk);
        end
        s_tvalid <= 1;
        s_tuser <= cmd;
        s_tdata <= d;
        do
            @(posedge clk);
        while (!s_tready);
        board.note_input(cmd, d);
    endtask

    task automatic load(int a, int b, logic [15:0] c);
        send(mfbfs_pkg::CMD_LOAD, {8'h0, c, b[3:0], a[3:0]});
    endtask

    task automatic run(int s, int t);
        send(mfbfs_pkg::CMD_RUN, {t[3:0], s[3:0], 24'h0});
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (board.pending.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // Random graph traffic; small graphs with many paths, some dense loads.
    task automatic random_phase(int count);
        int k;
        int w;
        k = 0;
        while (k < count)
        begin
            w = $urandom_range(99);
            if (w < 70)
                load($urandom_range(N-1), $urandom_range(N-1),
                     ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(40)));
            else if (w < 75)
                load($urandom_range(N-1), $urandom_range(N-1), 16'h0);
            else if (w < 78)
                run($urandom_range(N-1), $urandom_range(N-1));
            else
            begin
                int s;
                int t;
                s = $urandom_range(N-1);
                t = (s + 1 + $urandom_range(N-2)) % N;
                run(s, t);
            end
            k++;
        end
    endtask

    initial
    begin
        board = new();
        board.clear();
        hold_off = 0;
        src_idle_pct = 0;
        dst_stall_pct = 0;
        rst_n = 0;
        s_tvalid = 0;
        s_tdata = '0;
        s_tuser = mfbfs_pkg::CMD_LOAD;
        repeat (4) @(posedge clk);
        rst_n <= 1;

        // Directed: empty graph, equal ends, extremes, chain, parallel paths.
        run(0, 15);
        run(5, 5);
        run(15, 15);
        load(0, 15, 16'hFFFF);
        load(15, 0, 16'hFFFF);
        load(7, 7, 16'h1234);
        run(0, 15);
        run(15, 0);
        load(0, 1, 16'd10);
        load(1, 2, 16'd4);
        load(2, 15, 16'd9);
        load(0, 3, 16'd8);
        load(3, 2, 16'd6);
        load(1, 3, 16'd2);
        run(0, 15);
        run(0, 2);
        run(2, 0);
        run(7, 8);
        load(0, 15, 16'h0);
        run(0, 15);
        run(0, 0);
        drain();

        for (int i = 1; i < N; i++)
            load(0, i, 16'hFFFF);
        for (int i = 1; i < N - 1; i++)
            load(i, N - 1, 16'hFFFF);
        run(0, N - 1);
        drain();

        src_idle_pct = 0;  dst_stall_pct = 0;  random_phase(430);
        drain();
        src_idle_pct = 47; dst_stall_pct = 0;  random_phase(430);
        drain();
        src_idle_pct = 0;  dst_stall_pct = 47; random_phase(430);
        drain();
        src_idle_pct = 22; dst_stall_pct = 22;
        hold_off = 3000;
        run(1, 2);
        run(3, 4);
        run(5, 5);
        random_phase(430);
        drain();

        $display("Covered %0d loads and %0d runs (%0d with equal ends) under four idle mixes.",
                 board.loads, board.runs, board.same_runs);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end
endmodule
